FILE: rtl/ffvp_pkg.sv
`timescale 1ns / 1ps

package ffvp_pkg;

    // Field widths
    localparam int MODE_W     = 5;
    localparam int INTERVAL_W = 30;
    localparam int TIME_W     = 63;
    localparam int MULT_CMP_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FF_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_INTERVAL = 8'd1;

    // Register reset values
    localparam logic [MODE_W-1:0]     FF_MODE_RST  = 5'd1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 30'd16666667;

    // Parameter defaults
    localparam int MAX_MULTIPLIER_DEF     = 16;
    localparam int UNLIMITED_FLOOR_NS_DEF = 1000000;

    // Divider: one quotient bit per step over the interval width
    localparam int DIV_STEPS = INTERVAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = MODE_W + 1;

    typedef struct packed {
        logic              is_running;
        logic              frame_stepping;
        logic              seek_catchup;
        logic [TIME_W-1:0] host_time_ns;
    } in_item_t;

    typedef struct packed {
        logic                  present_frame;
        logic [INTERVAL_W-1:0] timer_period_ns;
        logic [INTERVAL_W-1:0] wake_period_ns;
        logic [INTERVAL_W-1:0] guest_advance_ns;
    } out_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]     ff_mode;
        logic [INTERVAL_W-1:0] frame_interval_ns;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/fast_forward_vblank_pacer.sv
`timescale 1ns / 1ps

// Channel   | Ports                                    | Moves
// ----------+------------------------------------------+-------------------------------
// input     | s_valid, s_ready, s_data                 | one vblank event request
// result    | m_valid, m_ready, m_data                 | one pacing result request
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write request
//
// An item holds the sequencer from the load cycle in which it is accepted, through 30
// steps of the bit-serial interval divider, to the commit that writes its result to
// the output register; a new request is taken only after that commit, once the
// sequencer is idle again. The output register lets a new request enter while a
// result still waits; a stalled result side holds the sequencer at commit.
// Reset is synchronous on aresetn low, returns all pacing state and drops ready.

module fast_forward_vblank_pacer
    import ffvp_pkg::*;
#(
    parameter int MAX_MULTIPLIER     = MAX_MULTIPLIER_DEF,
    parameter int UNLIMITED_FLOOR_NS = UNLIMITED_FLOOR_NS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers
    ffvp_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    ffvp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Divider, frame decision and output register
    ffvp_dp #(
        .MAX_MULTIPLIER     (MAX_MULTIPLIER),
        .UNLIMITED_FLOOR_NS (UNLIMITED_FLOOR_NS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/ffvp_regs.sv
`timescale 1ns / 1ps

module ffvp_regs
    import ffvp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [MODE_W-1:0]     ff_mode_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // Writes are taken whenever the block is out of reset; an unknown index is dropped.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_mode_reg  <= FF_MODE_RST;
            interval_reg <= INTERVAL_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IDX_FF_MODE) begin
                ff_mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (cfg_index == CFG_IDX_INTERVAL) begin
                interval_reg <= cfg_data[INTERVAL_W-1:0];
            end
        end
    end

    assign cfg.ff_mode           = ff_mode_reg;
    assign cfg.frame_interval_ns = interval_reg;

endmodule

FILE: rtl/ffvp_ctrl.sv
`timescale 1ns / 1ps

module ffvp_ctrl
    import ffvp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(DIV_STEPS - 1);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [DIV_CNT_W-1:0] step_cnt_reg;
    logic [DIV_CNT_W-1:0] step_cnt_next;

    // Requests are taken only in idle and never while reset is held.
    assign s_ready = aresetn && (state_reg == ST_IDLE);

    // Sequencing: take a request, run the divider, then commit the result.
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LastStep) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register can take the result.
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

endmodule

FILE: rtl/ffvp_dp.sv
`timescale 1ns / 1ps

module ffvp_dp
    import ffvp_pkg::*;
#(
    parameter int MAX_MULTIPLIER     = MAX_MULTIPLIER_DEF,
    parameter int UNLIMITED_FLOOR_NS = UNLIMITED_FLOOR_NS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  cfg_t       cfg,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam logic [MULT_CMP_W-1:0] MaxMult = MULT_CMP_W'(MAX_MULTIPLIER);
    localparam logic [INTERVAL_W-1:0] Floor   = INTERVAL_W'(UNLIMITED_FLOOR_NS);
    localparam logic [MODE_W-1:0]     ModeOne = MODE_W'(1);

    // Item and divider registers
    in_item_t              item_reg;
    logic [TIME_W-1:0]     diff_reg;
    logic                  borrow_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [INTERVAL_W-1:0] quo_reg;
    logic [MODE_W-1:0]     divisor_reg;

    // Pacing state
    logic [MODE_W-1:0]     skip_count_reg;
    logic [MODE_W-1:0]     skip_count_next;
    logic [MODE_W-1:0]     prior_mult_reg;
    logic [MODE_W-1:0]     prior_mult_next;
    logic                  prior_unl_reg;
    logic                  prior_unl_next;
    logic [TIME_W-1:0]     last_present_reg;
    logic [TIME_W-1:0]     last_present_next;

    // Output register
    logic                  out_valid_reg;
    out_item_t             out_reg;
    out_item_t             out_next;

    logic [MODE_W-1:0]     cfg_mode;
    logic [INTERVAL_W-1:0] interval;
    logic [REM_W-1:0]      trial;
    logic [TIME_W:0]       sub_full;
    logic                  run_free;
    logic [MODE_W-1:0]     eff_mode;
    logic [MODE_W-1:0]     wake_mode;
    logic                  unl;
    logic [MODE_W-1:0]     mult;
    logic                  changed;
    logic                  present;
    logic [MODE_W:0]       skip_inc;
    logic [INTERVAL_W-1:0] q_min1;
    logic [INTERVAL_W-1:0] iv_min1;

    // Saturate the configured mode at the largest multiplier.
    assign cfg_mode = ({{(MULT_CMP_W-MODE_W){1'b0}}, cfg.ff_mode} > MaxMult)
                      ? MaxMult[MODE_W-1:0] : cfg.ff_mode;
    assign interval = cfg.frame_interval_ns;

    // Elapsed time against the stored present time, taken at load.
    assign sub_full = {1'b0, s_data.host_time_ns} - {1'b0, last_present_reg};

    // One restoring division step per cycle: interval / mode.
    assign trial = {rem_reg[REM_W-2:0], quo_reg[INTERVAL_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg    <= s_data;
            diff_reg    <= sub_full[TIME_W-1:0];
            borrow_reg  <= sub_full[TIME_W];
            rem_reg     <= '0;
            quo_reg     <= interval;
            divisor_reg <= (cfg_mode > ModeOne) ? cfg_mode : ModeOne;
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, divisor_reg}) begin
                rem_reg <= trial - {1'b0, divisor_reg};
                quo_reg <= {quo_reg[INTERVAL_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[INTERVAL_W-2:0], 1'b0};
            end
        end
    end

    // Effective modes for the frame decision and for the wake period.
    assign run_free  = item_reg.is_running && !item_reg.frame_stepping;
    assign eff_mode  = run_free ? cfg_mode : ModeOne;
    assign wake_mode = item_reg.is_running ? cfg_mode : ModeOne;
    assign unl       = (eff_mode == '0);
    assign mult      = (eff_mode > ModeOne) ? eff_mode : ModeOne;
    assign changed   = (unl != prior_unl_reg) || (mult != prior_mult_reg);
    assign skip_inc  = (changed ? '0 : {1'b0, skip_count_reg}) + 1'b1;
    assign q_min1    = (quo_reg == '0) ? INTERVAL_W'(1) : quo_reg;
    assign iv_min1   = (interval == '0) ? INTERVAL_W'(1) : interval;

    // Frame decision and state update.
    always_comb begin
        skip_count_next   = skip_count_reg;
        prior_mult_next   = prior_mult_reg;
        prior_unl_next    = prior_unl_reg;
        last_present_next = last_present_reg;
        present           = 1'b1;
        if (item_reg.frame_stepping && item_reg.seek_catchup) begin
            present = 1'b0;
        end else begin
            if (changed) begin
                skip_count_next   = '0;
                last_present_next = item_reg.host_time_ns;
                prior_mult_next   = mult;
                prior_unl_next    = unl;
            end
            if (unl) begin
                // A mode change restarts the elapsed time at zero.
                if (changed) begin
                    present = (interval == '0);
                end else begin
                    present = !borrow_reg &&
                              (diff_reg >= {{(TIME_W-INTERVAL_W){1'b0}}, interval});
                end
                if (present) begin
                    last_present_next = item_reg.host_time_ns;
                end
            end else if (mult > ModeOne) begin
                if (skip_inc >= {1'b0, mult}) begin
                    skip_count_next = '0;
                end else begin
                    skip_count_next = skip_inc[MODE_W-1:0];
                    present         = 1'b0;
                end
            end
        end
    end

    // Result fields.
    always_comb begin
        out_next.present_frame = present;
        if (eff_mode == '0) begin
            out_next.timer_period_ns = Floor;
        end else if (eff_mode == ModeOne) begin
            out_next.timer_period_ns = iv_min1;
        end else begin
            out_next.timer_period_ns = q_min1;
        end
        if (wake_mode == '0) begin
            out_next.wake_period_ns = Floor;
        end else if (wake_mode == ModeOne) begin
            out_next.wake_period_ns = iv_min1;
        end else begin
            out_next.wake_period_ns = q_min1;
        end
        out_next.guest_advance_ns = '0;
        if (run_free && (cfg_mode != ModeOne)) begin
            if (cfg_mode == '0) begin
                if (interval > Floor) begin
                    out_next.guest_advance_ns = interval - Floor;
                end
            end else begin
                out_next.guest_advance_ns = interval - quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg   <= '0;
            prior_mult_reg   <= ModeOne;
            prior_unl_reg    <= 1'b0;
            last_present_reg <= '0;
        end else if (cmd.commit) begin
            skip_count_reg   <= skip_count_next;
            prior_mult_reg   <= prior_mult_next;
            prior_unl_reg    <= prior_unl_next;
            last_present_reg <= last_present_next;
        end
    end

    // Output register decouples the result side from the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

endmodule
